// ----- hdl/vndc_pkg.sv -----
// Shared types, codes and helper functions for the neighbor direction classifier.
// No dependencies; every other file of the block but vndc_chan_if refers to this package by scope.
package vndc_pkg;

    localparam int NEIGHBOR_ENTRIES = 32;

    localparam int SENDER_W   = 16;
    localparam int HEADING_W  = 9;
    localparam int COORD_W    = 20;
    localparam int TIME_W     = 32;
    localparam int CLASS_W    = 2;
    localparam int ACTION_W   = 2;
    localparam int CNT_W      = 6;
    localparam int ROI_W      = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI     = 1'd1;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [ROI_W-1:0]  ROI_RESET     = 20'd12500;

    localparam logic [HEADING_W-1:0] DEG_45  = 9'd45;
    localparam logic [HEADING_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEADING_W-1:0] DEG_135 = 9'd135;
    localparam logic [HEADING_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEADING_W-1:0] DEG_225 = 9'd225;
    localparam logic [HEADING_W-1:0] DEG_315 = 9'd315;
    localparam logic [HEADING_W-1:0] DEG_360 = 9'd360;

    localparam logic [CLASS_W-1:0] REL_AHEAD = 2'd0;
    localparam logic [CLASS_W-1:0] REL_BACK  = 2'd1;
    localparam logic [CLASS_W-1:0] REL_OPP   = 2'd2;
    localparam logic [CLASS_W-1:0] REL_NONE  = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RB_STORE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RB_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STORE    = 2'd3;

    typedef struct packed {
        logic                 is_data;
        logic [SENDER_W-1:0]  sender_id;
        logic [HEADING_W-1:0] sender_heading;
        logic [COORD_W-1:0]   sender_x;
        logic [COORD_W-1:0]   sender_y;
        logic [TIME_W-1:0]    sent_time;
        logic [HEADING_W-1:0] own_heading;
        logic [COORD_W-1:0]   own_x;
        logic [COORD_W-1:0]   own_y;
        logic [TIME_W-1:0]    now_time;
    } t_in_item;

    typedef struct packed {
        logic                same_direction;
        logic [CLASS_W-1:0]  relation;
        logic                mdc;
        logic                odc;
        logic                dflg;
        logic                relay_stored_first;
        logic [ACTION_W-1:0] data_action;
        logic                table_overflow;
        logic [CNT_W-1:0]    ahead_count;
        logic [CNT_W-1:0]    back_count;
        logic [CNT_W-1:0]    opposite_count;
    } t_out_item;

    typedef struct packed {
        logic                same;
        logic [CLASS_W-1:0]  rel;
        logic                roi_in;
    } t_cls;

    typedef struct packed {
        logic                valid;
        logic [SENDER_W-1:0] sender;
        logic [CLASS_W-1:0]  cls;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                start;
        logic                file;
        logic [SENDER_W-1:0] sender_id;
        logic [CLASS_W-1:0]  cls;
        logic [TIME_W-1:0]   stamp;
        logic [TIME_W-1:0]   now;
    } t_tbl_req;

    typedef struct packed {
        logic ready;
        logic done;
        logic overflow;
    } t_tbl_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASS,
        ST_TABLE
    } t_top_state;

    typedef enum logic [1:0] {
        TB_CLEAR,
        TB_IDLE,
        TB_SWEEP,
        TB_WRITE
    } t_tbl_state;

    function automatic logic [HEADING_W-1:0] f_norm_heading(input logic [HEADING_W-1:0] h);
        return (h >= DEG_360) ? h - DEG_360 : h;
    endfunction

    function automatic logic f_stale(input logic [TIME_W-1:0] stamp,
                                     input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] timeout);
        return (now > stamp) && ((now - stamp) > timeout);
    endfunction

endpackage

// ----- hdl/vndc_chan_if.sv -----
// Valid/ready channel carrying one request payload of a chosen packed type.
// Uses no package; payload types come from vndc_pkg at the instantiation.
interface vndc_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/vehicle_neighbor_direction_classifier.sv -----
// A request is registered, classified, swept through the table and then loaded into the output register.
// A new request is taken only once the previous result has been loaded; the table sweep
// reads one memory entry per cycle through the single read port and writes back only the entries it drops.
// Reset: a clearing pass empties the table; no request is taken during it. Timeout resets
// to 5000 ms, region half size to 12500, MDC to zero.
// Depends on vndc_pkg, vndc_chan_if, vndc_classify, vndc_table and vndc_ram.
module vehicle_neighbor_direction_classifier #(
    parameter int NEIGHBOR_ENTRIES = vndc_pkg::NEIGHBOR_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vndc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vndc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vndc_chan_if.sink                          i_in,
    vndc_chan_if.source                        o_out
);

    localparam int CW    = $clog2(NEIGHBOR_ENTRIES + 1);
    localparam int SUM_W = CW + 2;

    vndc_pkg::t_top_state r_state, n_state;

    vndc_pkg::t_in_item              r_item;
    vndc_pkg::t_cls                  cls_c;
    vndc_pkg::t_cls                  r_cls;
    logic [vndc_pkg::TIME_W-1:0]     r_timeout;
    logic [vndc_pkg::ROI_W-1:0]      r_roi;
    logic                            r_mdc;
    logic                            r_out_vld;
    vndc_pkg::t_out_item             r_out;
    vndc_pkg::t_out_item             n_out;

    vndc_pkg::t_tbl_req              tbl_req;
    vndc_pkg::t_tbl_stat             tbl_stat;
    logic [CW-1:0]                   cnt_a;
    logic [CW-1:0]                   cnt_b;
    logic [CW-1:0]                   cnt_o;
    logic [SUM_W-1:0]                cnt_sum;

    logic                            accept;
    logic                            load;
    logic                            mdc;
    logic                            odc;
    logic                            dflg;

    vndc_classify u_classify (
        .i_item (r_item),
        .i_roi  (r_roi),
        .o_cls  (cls_c)
    );

    vndc_table #(
        .ENTRIES (NEIGHBOR_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (tbl_req),
        .i_timeout   (r_timeout),
        .o_stat      (tbl_stat),
        .o_cnt_ahead (cnt_a),
        .o_cnt_back  (cnt_b),
        .o_cnt_opp   (cnt_o)
    );

    assign i_in.ready = (r_state == vndc_pkg::ST_IDLE) && tbl_stat.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign load       = (r_state == vndc_pkg::ST_TABLE) && tbl_stat.done &&
                        (!r_out_vld || o_out.ready);

    always_comb begin
        n_state           = r_state;
        tbl_req.start     = 1'b0;
        tbl_req.file      = r_cls.rel != vndc_pkg::REL_NONE;
        tbl_req.cls       = r_cls.rel;
        tbl_req.sender_id = r_item.sender_id;
        tbl_req.stamp     = r_item.sent_time;
        tbl_req.now       = r_item.now_time;
        unique case (r_state)
            vndc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = vndc_pkg::ST_CLASS;
                end
            end
            vndc_pkg::ST_CLASS: begin
                tbl_req.start = 1'b1;
                n_state       = vndc_pkg::ST_TABLE;
            end
            vndc_pkg::ST_TABLE: begin
                if (load) begin
                    n_state = vndc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vndc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        odc  = cnt_o != '0;
        mdc  = !((r_cls.same && cnt_b == '0 && cnt_a != '0) ||
                 (!r_cls.same && cnt_b != '0 && cnt_a == '0));
        dflg = r_item.is_data && r_cls.roi_in;

        n_out.same_direction     = r_cls.same;
        n_out.relation           = r_cls.rel;
        n_out.mdc                = mdc;
        n_out.odc                = odc;
        n_out.dflg               = dflg;
        n_out.relay_stored_first = !r_cls.same || r_mdc;
        n_out.table_overflow     = tbl_stat.overflow;
        n_out.ahead_count        = vndc_pkg::CNT_W'(cnt_a);
        n_out.back_count         = vndc_pkg::CNT_W'(cnt_b);
        n_out.opposite_count     = vndc_pkg::CNT_W'(cnt_o);
        if (!r_item.is_data || mdc) begin
            n_out.data_action = vndc_pkg::ACT_NONE;
        end else if (odc) begin
            n_out.data_action = dflg ? vndc_pkg::ACT_RB_CLEAR : vndc_pkg::ACT_RB_STORE;
        end else begin
            n_out.data_action = vndc_pkg::ACT_STORE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vndc_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_mdc     <= 1'b0;
            r_timeout <= vndc_pkg::TIMEOUT_RESET;
            r_roi     <= vndc_pkg::ROI_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vndc_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    vndc_pkg::CFG_ROI:     r_roi     <= i_cfg_data[vndc_pkg::ROI_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (load) begin
                r_out_vld <= 1'b1;
                r_mdc     <= mdc;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
        if (r_state == vndc_pkg::ST_CLASS) begin
            r_cls <= cls_c;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign cnt_sum = SUM_W'(cnt_a) + SUM_W'(cnt_b) + SUM_W'(cnt_o);

    a_done_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(tbl_stat.done) |-> r_state == vndc_pkg::ST_TABLE)
        else $error("table finished while no request was waiting");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_stat.done |-> cnt_sum <= SUM_W'(NEIGHBOR_ENTRIES))
        else $error("live neighbor count exceeds table size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_stat.done && tbl_stat.overflow |-> cnt_sum == SUM_W'(NEIGHBOR_ENTRIES))
        else $error("overflow reported with free table slots");

endmodule

// ----- hdl/vndc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on vndc_pkg for default sizes only.
module vndc_ram #(
    parameter int WIDTH = vndc_pkg::ENTRY_W,
    parameter int DEPTH = vndc_pkg::NEIGHBOR_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/vndc_classify.sv -----
// Heading difference, direction class and interest-region test for one request.
// Depends on vndc_pkg for field types, heading constants and relation codes.
module vndc_classify (
    input  vndc_pkg::t_in_item                i_item,
    input  logic [vndc_pkg::ROI_W-1:0]        i_roi,
    output vndc_pkg::t_cls                    o_cls
);

    localparam int DW = vndc_pkg::COORD_W + 2;

    logic [vndc_pkg::HEADING_W-1:0] sh;
    logic [vndc_pkg::HEADING_W-1:0] oh;
    logic [vndc_pkg::HEADING_W-1:0] d0;
    logic [vndc_pkg::HEADING_W-1:0] diff;
    logic                           same;
    logic                           ahead;
    logic signed [DW-1:0]           dx;
    logic signed [DW-1:0]           dy;
    logic signed [DW-1:0]           rr;

    always_comb begin
        sh   = vndc_pkg::f_norm_heading(i_item.sender_heading);
        oh   = vndc_pkg::f_norm_heading(i_item.own_heading);
        d0   = (oh > sh) ? oh - sh : sh - oh;
        diff = (d0 > vndc_pkg::DEG_180) ? vndc_pkg::DEG_360 - d0 : d0;
        same = diff < vndc_pkg::DEG_45;

        if (sh < vndc_pkg::DEG_45 || sh >= vndc_pkg::DEG_315) begin
            ahead = i_item.own_x <= i_item.sender_x;
        end else if (sh < vndc_pkg::DEG_135) begin
            ahead = i_item.own_y <= i_item.sender_y;
        end else if (sh < vndc_pkg::DEG_225) begin
            ahead = i_item.own_x >= i_item.sender_x;
        end else begin
            ahead = i_item.own_y >= i_item.sender_y;
        end

        dx = $signed({2'b00, i_item.own_x}) - $signed({2'b00, i_item.sender_x});
        dy = $signed({2'b00, i_item.own_y}) - $signed({2'b00, i_item.sender_y});
        rr = $signed({2'b00, i_roi});

        o_cls.same   = same;
        o_cls.roi_in = (dx > -rr) && (dx < rr) && (dy > -rr) && (dy < rr);
        if (same) begin
            o_cls.rel = ahead ? vndc_pkg::REL_AHEAD : vndc_pkg::REL_BACK;
        end else if (diff > vndc_pkg::DEG_90) begin
            o_cls.rel = vndc_pkg::REL_OPP;
        end else begin
            o_cls.rel = vndc_pkg::REL_NONE;
        end
    end

endmodule

// ----- hdl/vndc_table.sv -----
// Neighbor table engine: clearing pass, read-modify-write sweep, insert, class counts.
// Depends on vndc_pkg and vndc_ram.
module vndc_table #(
    parameter int ENTRIES = vndc_pkg::NEIGHBOR_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vndc_pkg::t_tbl_req                i_req,
    input  logic [vndc_pkg::TIME_W-1:0]       i_timeout,
    output vndc_pkg::t_tbl_stat               o_stat,
    output logic [$clog2(ENTRIES+1)-1:0]      o_cnt_ahead,
    output logic [$clog2(ENTRIES+1)-1:0]      o_cnt_back,
    output logic [$clog2(ENTRIES+1)-1:0]      o_cnt_opp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    vndc_pkg::t_tbl_state r_state, n_state;

    logic [AW-1:0]  r_addr;
    logic           r_go;
    logic           r_chk_vld;
    logic [AW-1:0]  r_chk_addr;
    logic           r_found;
    logic [AW-1:0]  r_free_addr;
    logic [CW-1:0]  r_cnt_a;
    logic [CW-1:0]  r_cnt_b;
    logic [CW-1:0]  r_cnt_o;
    logic           r_ovf;
    logic           r_done;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    vndc_pkg::t_entry              ram_wdata;
    logic                          ram_re;
    logic [vndc_pkg::ENTRY_W-1:0]  ram_rdata;
    vndc_pkg::t_entry              rd_ent;

    logic                           keep;
    logic                           ins_ok;
    logic                           cnt_en;
    logic [vndc_pkg::CLASS_W-1:0]   cnt_cls;

    vndc_ram #(
        .WIDTH (vndc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = ram_rdata;
    assign ram_re = (r_state == vndc_pkg::TB_SWEEP) && r_go;

    assign keep = rd_ent.valid &&
                  !(i_req.file &&
                    ((rd_ent.sender == i_req.sender_id) ||
                     vndc_pkg::f_stale(rd_ent.stamp, i_req.now, i_timeout)));
    assign ins_ok = i_req.file && !vndc_pkg::f_stale(i_req.stamp, i_req.now, i_timeout);

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        cnt_en    = 1'b0;
        cnt_cls   = rd_ent.cls;
        unique case (r_state)
            vndc_pkg::TB_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = vndc_pkg::TB_IDLE;
                end
            end
            vndc_pkg::TB_IDLE: begin
                if (i_req.start) begin
                    n_state = vndc_pkg::TB_SWEEP;
                end
            end
            vndc_pkg::TB_SWEEP: begin
                if (r_chk_vld) begin
                    ram_we          = keep != rd_ent.valid;
                    ram_waddr       = r_chk_addr;
                    ram_wdata       = rd_ent;
                    ram_wdata.valid = keep;
                    cnt_en          = keep;
                    if (r_chk_addr == LAST) begin
                        n_state = vndc_pkg::TB_WRITE;
                    end
                end
            end
            vndc_pkg::TB_WRITE: begin
                ram_we           = ins_ok && r_found;
                ram_waddr        = r_free_addr;
                ram_wdata.valid  = 1'b1;
                ram_wdata.sender = i_req.sender_id;
                ram_wdata.cls    = i_req.cls;
                ram_wdata.stamp  = i_req.stamp;
                cnt_en           = ins_ok && r_found;
                cnt_cls          = i_req.cls;
                n_state          = vndc_pkg::TB_IDLE;
            end
            default: begin
                n_state = vndc_pkg::TB_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vndc_pkg::TB_CLEAR;
            r_addr    <= '0;
            r_go      <= 1'b0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chk_vld  <= ram_re;
            r_chk_addr <= r_addr;
            case (r_state)
                vndc_pkg::TB_CLEAR: begin
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                end
                vndc_pkg::TB_IDLE: begin
                    if (i_req.start) begin
                        r_addr  <= '0;
                        r_go    <= 1'b1;
                        r_found <= 1'b0;
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_cnt_o <= '0;
                        r_done  <= 1'b0;
                    end
                end
                vndc_pkg::TB_SWEEP: begin
                    if (r_go) begin
                        if (r_addr == LAST) begin
                            r_go <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_chk_vld && !keep && !r_found) begin
                        r_found     <= 1'b1;
                        r_free_addr <= r_chk_addr;
                    end
                end
                vndc_pkg::TB_WRITE: begin
                    r_done <= 1'b1;
                    r_ovf  <= ins_ok && !r_found;
                end
                default: begin
                end
            endcase
            if (cnt_en) begin
                case (cnt_cls)
                    vndc_pkg::REL_AHEAD: r_cnt_a <= r_cnt_a + 1'b1;
                    vndc_pkg::REL_BACK:  r_cnt_b <= r_cnt_b + 1'b1;
                    vndc_pkg::REL_OPP:   r_cnt_o <= r_cnt_o + 1'b1;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stat.ready    = r_state == vndc_pkg::TB_IDLE;
    assign o_stat.done     = r_done;
    assign o_stat.overflow = r_ovf;
    assign o_cnt_ahead     = r_cnt_a;
    assign o_cnt_back      = r_cnt_b;
    assign o_cnt_opp       = r_cnt_o;

endmodule
